### hdl/kmsd_pkg.sv
package kmsd_pkg;

  // Fixed field widths.
  localparam int unsigned ColumnW   = 5;
  localparam int unsigned RowBitsW  = 8;
  localparam int unsigned RowIndexW = 3;
  localparam int unsigned RowDataW  = 32;
  localparam int unsigned KeyCountW = 9;
  localparam int unsigned ScansW    = 8;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 8;

  // Configuration register indexes.
  typedef enum logic [CfgIndexW-1:0] {
    CFG_DEBOUNCE_SCANS = 2'd0,
    CFG_CAPS_ENABLE    = 2'd1,
    CFG_CAPS_COLUMN    = 2'd2,
    CFG_CAPS_ROW       = 2'd3
  } cfg_index_t;

  // Request kinds carried on the input tuser.
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  // Reset values.
  localparam logic [ScansW-1:0]    DebounceScansReset = 8'd5;
  localparam logic                 CapsEnableReset    = 1'b1;
  localparam logic [ColumnW-1:0]   CapsColumnReset    = 5'd0;
  localparam logic [RowIndexW-1:0] CapsRowReset       = 3'd3;

  typedef struct packed {
    logic [ScansW-1:0]    debounce_scans;
    logic                 caps_enable;
    logic [ColumnW-1:0]   caps_column;
    logic [RowIndexW-1:0] caps_row;
  } cfg_t;

  typedef struct packed {
    logic                 req_type;
    logic [ColumnW-1:0]   column;
    logic [RowBitsW-1:0]  row_bits;
    logic                 caps_pressed;
    logic                 end_of_scan;
    logic [RowIndexW-1:0] row_index;
  } item_t;

  typedef struct packed {
    logic                 settled;
    logic                 bounce;
    logic [RowDataW-1:0]  row_data;
    logic [KeyCountW-1:0] key_count;
  } result_t;

endpackage

### hdl/key_matrix_scan_debounce_core.sv
// Channel   Direction  Handshake                   Payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tdata, tuser = req_type, tlast = end_of_scan
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata = result fields
// cfg       in         cfg_we (no wait)             cfg_index, cfg_wdata
//
// A transaction accepted at one edge sits in the input register and is
// processed combinationally; its result is captured in the output register
// when the held transaction advances and is then offered on m_axis, and one
// transaction per cycle is sustained while m_axis does not stall.
// The matrix update and key total are combinational because the total is
// kept incrementally from the column delta.
// Reset is synchronous and active high; it clears both matrices, totals and
// valid flags and sets countdown and config to defaults. A stall on m_axis holds the output
// register, and s_axis_tready drops only once the input register is also full.
module key_matrix_scan_debounce_core
  import kmsd_pkg::*;
#(
  parameter int unsigned ROWS = 8,
  parameter int unsigned COLS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [4:0] column, [12:5] row_bits, [13] caps_pressed, [16:14] row_index,
  // [23:17] zero
  input  logic [23:0]          s_axis_tdata,
  // [0] req_type
  input  logic                 s_axis_tuser,
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [0] settled, [1] bounce, [33:2] row_data, [42:34] key_count, [47:43] zero
  output logic [47:0]          m_axis_tdata,
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_wdata
);

  cfg_t    cfg;
  item_t   item;
  logic    in_valid;
  logic    advance;
  result_t result;
  result_t out_data;
  logic    out_valid;

  kmsd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // The held transaction moves on when the output register is empty or is
  // being drained in the same cycle.
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item.req_type     <= s_axis_tuser;
      item.column       <= s_axis_tdata[4:0];
      item.row_bits     <= s_axis_tdata[12:5];
      item.caps_pressed <= s_axis_tdata[13];
      item.end_of_scan  <= s_axis_tlast;
      item.row_index    <= s_axis_tdata[16:14];
    end
  end

  kmsd_engine #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .item    (item),
    .advance (advance),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_data.key_count, out_data.row_data,
                          out_data.bounce, out_data.settled};

endmodule

### hdl/kmsd_cfg.sv
module kmsd_cfg
  import kmsd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_wdata,
  output cfg_t                 cfg
);

  cfg_index_t idx;
  assign idx = cfg_index_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_scans <= DebounceScansReset;
      cfg.caps_enable    <= CapsEnableReset;
      cfg.caps_column    <= CapsColumnReset;
      cfg.caps_row       <= CapsRowReset;
    end else if (cfg_we) begin
      case (idx)
        CFG_DEBOUNCE_SCANS: cfg.debounce_scans <= cfg_wdata[ScansW-1:0];
        CFG_CAPS_ENABLE:    cfg.caps_enable    <= cfg_wdata[0];
        CFG_CAPS_COLUMN:    cfg.caps_column    <= cfg_wdata[ColumnW-1:0];
        CFG_CAPS_ROW:       cfg.caps_row       <= cfg_wdata[RowIndexW-1:0];
        default: ;
      endcase
    end
  end

endmodule

### hdl/kmsd_engine.sv
module kmsd_engine
  import kmsd_pkg::*;
#(
  parameter int unsigned ROWS = 8,
  parameter int unsigned COLS = 32
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  item_t   item,
  input  logic    advance,
  output result_t result
);

  localparam int unsigned RowCntW = $clog2(ROWS + 1);
  localparam int unsigned ReadRows = 2 ** RowIndexW;

  logic [COLS-1:0] raw [ROWS];
  logic [COLS-1:0] stable [ROWS];
  logic [ScansW-1:0]    countdown;
  logic [KeyCountW-1:0] raw_total;
  logic [KeyCountW-1:0] pressed_total;

  logic [COLS-1:0] raw_next [ROWS];
  logic [ScansW-1:0]    countdown_next;
  logic [KeyCountW-1:0] raw_total_next;
  logic [KeyCountW-1:0] pressed_total_next;

  logic [RowDataW-1:0] sel_wide;
  logic [COLS-1:0]     sel;
  logic                col_ok;
  logic                caps_hit;
  logic [RowBitsW-1:0] merged;
  logic [ROWS-1:0]     prev;
  logic [ROWS-1:0]     diff;
  logic                changed;
  logic [RowCntW-1:0]  prev_n;
  logic [RowCntW-1:0]  cur_n;
  logic [ScansW-1:0]   cd_mid;
  logic [ScansW-1:0]   cd_dec;
  logic                publish;
  logic                is_sample;
  logic [RowDataW-1:0] stable_view [ReadRows];

  // One-hot column select; columns past the matrix width select nothing.
  assign sel_wide = RowDataW'(1) << item.column;
  assign sel      = sel_wide[COLS-1:0];
  assign col_ok   = |sel;

  assign caps_hit = cfg.caps_enable && item.caps_pressed && (item.column == cfg.caps_column);
  assign merged   = item.row_bits | (caps_hit ? (RowBitsW'(1) << cfg.caps_row) : '0);

  always_comb begin
    prev_n = '0;
    cur_n  = '0;
    for (int r = 0; r < ROWS; r++) begin
      prev[r]     = |(raw[r] & sel);
      diff[r]     = col_ok && (prev[r] != merged[r]);
      raw_next[r] = (raw[r] & ~sel) | (merged[r] ? sel : '0);
      prev_n      = prev_n + RowCntW'(prev[r]);
      cur_n       = cur_n + RowCntW'(merged[r] && col_ok);
    end
  end

  assign changed   = |diff;
  assign is_sample = (item.req_type == REQ_SAMPLE);

  // Any change restarts the countdown; end of scan then counts it down.
  always_comb begin
    cd_mid  = changed ? cfg.debounce_scans : countdown;
    cd_dec  = cd_mid - ScansW'(1);
    publish = 1'b0;
    countdown_next = cd_mid;
    if (item.end_of_scan) begin
      if (cd_mid != '0) begin
        countdown_next = cd_dec;
        publish        = (cd_dec == '0);
      end else begin
        publish = 1'b1;
      end
    end
  end

  // The raw key total tracks the column delta, so publishing is a copy.
  assign raw_total_next     = raw_total - KeyCountW'(prev_n) + KeyCountW'(cur_n);
  assign pressed_total_next = publish ? raw_total_next : pressed_total;

  for (genvar i = 0; i < ReadRows; i++) begin : g_read
    if (i < ROWS) begin : g_row
      assign stable_view[i] = RowDataW'(stable[i]);
    end else begin : g_none
      assign stable_view[i] = '0;
    end
  end

  always_comb begin
    if (is_sample) begin
      result.settled   = (countdown_next == '0);
      result.bounce    = changed && (countdown != '0);
      result.row_data  = '0;
      result.key_count = pressed_total_next;
    end else begin
      result.settled   = (countdown == '0);
      result.bounce    = 1'b0;
      result.row_data  = stable_view[item.row_index];
      result.key_count = pressed_total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROWS; r++) begin
        raw[r]    <= '0;
        stable[r] <= '0;
      end
      countdown     <= DebounceScansReset;
      raw_total     <= '0;
      pressed_total <= '0;
    end else if (advance && is_sample) begin
      for (int r = 0; r < ROWS; r++) begin
        raw[r] <= raw_next[r];
        if (publish) begin
          stable[r] <= raw_next[r];
        end
      end
      countdown     <= countdown_next;
      raw_total     <= raw_total_next;
      pressed_total <= pressed_total_next;
    end
  end

endmodule
